### hw/rtl/fsic_pkg.sv
`default_nettype none
package fsic_pkg;

  // Field and datapath widths
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned POS_FRAC_BITS = 14;
  localparam int unsigned CHANNEL_BITS  = 8;
  localparam int unsigned POS_BITS      = POS_FRAC_BITS + 2;
  // shape values stay within +/-32 in Q(F)
  localparam int unsigned SHAPE_BITS    = POS_FRAC_BITS + 6;
  localparam int unsigned ACC_BITS      = 64;
  localparam int unsigned COLOR_BITS    = 3 * CHANNEL_BITS;
  localparam int unsigned NUM_BITS      = VALUE_BITS + CHANNEL_BITS + 1;
  localparam int unsigned CFG_BITS      = (VALUE_BITS > COLOR_BITS) ? VALUE_BITS : COLOR_BITS;
  localparam int unsigned NODES         = 9;

  typedef logic [2:0] kind_t;
  typedef logic signed [SHAPE_BITS-1:0] shape_t;

  // Element kinds
  localparam kind_t KIND_TRI3  = 3'd0;
  localparam kind_t KIND_TRI6  = 3'd1;
  localparam kind_t KIND_QUAD4 = 3'd2;
  localparam kind_t KIND_QUAD8 = 3'd3;
  localparam kind_t KIND_QUAD9 = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MAX_VALUE      = 3'd0;
  localparam logic [2:0] REG_MIN_VALUE      = 3'd1;
  localparam logic [2:0] REG_COLOR_POSITIVE = 3'd2;
  localparam logic [2:0] REG_COLOR_NEGATIVE = 3'd3;
  localparam logic [2:0] REG_COLOR_NEUTRAL  = 3'd4;

  typedef struct packed {
    logic [2:0]                   element_kind;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [VALUE_BITS-1:0] node_value_1;
    logic signed [VALUE_BITS-1:0] node_value_2;
    logic signed [VALUE_BITS-1:0] node_value_3;
    logic signed [VALUE_BITS-1:0] node_value_4;
    logic signed [VALUE_BITS-1:0] node_value_5;
    logic signed [VALUE_BITS-1:0] node_value_6;
    logic signed [VALUE_BITS-1:0] node_value_7;
    logic signed [VALUE_BITS-1:0] node_value_8;
    logic signed [VALUE_BITS-1:0] node_value_9;
  } fe_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } fe_out_t;

endpackage
`default_nettype wire

### hw/rtl/fe_shape_interp_colormap.sv
`default_nettype none
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------
// item in   | start_i, busy_o           | in_item_i (fsic_pkg::fe_in_t)
// result    | done_o (one-cycle strobe) | result_o (fsic_pkg::fe_out_t)
// config    | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while busy_o is low; each result passes through
// the shape-function stages, the node-product lanes, the merge adders, the color
// decision and numerator registers and the per-channel divider pipeline that
// takes one quotient bit per stage.
// busy_o is high during reset and until the first clock edge after its release;
// config writes are always taken. Results cannot be stalled by the receiver.
module fe_shape_interp_colormap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  fsic_pkg::fe_in_t                   in_item_i,
  output logic                               done_o,
  output fsic_pkg::fe_out_t                  result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [2:0]                         cfg_index_i,
  input  logic [fsic_pkg::CFG_BITS-1:0]      cfg_data_i
);
  import fsic_pkg::*;

  localparam int unsigned Latency = 8 + CHANNEL_BITS;
  localparam int unsigned F = POS_FRAC_BITS;

  logic accept;
  logic busy_q;

  assign accept      = start_i && !busy_o;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // Configuration registers
  logic signed [VALUE_BITS-1:0] max_q, min_q;
  logic [COLOR_BITS-1:0]        cpos_q, cneg_q, cneu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '0;
      min_q  <= '0;
      cpos_q <= COLOR_BITS'(24'hFF0000);
      cneg_q <= COLOR_BITS'(24'h0000FF);
      cneu_q <= COLOR_BITS'(24'hFFFFFF);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAX_VALUE:      max_q  <= cfg_data_i[VALUE_BITS-1:0];
        REG_MIN_VALUE:      min_q  <= cfg_data_i[VALUE_BITS-1:0];
        REG_COLOR_POSITIVE: cpos_q <= cfg_data_i[COLOR_BITS-1:0];
        REG_COLOR_NEGATIVE: cneg_q <= cfg_data_i[COLOR_BITS-1:0];
        REG_COLOR_NEUTRAL:  cneu_q <= cfg_data_i[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Valid chain up to the dividers
  logic [7:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], accept};
    end
  end

  // Shape functions (three stages)
  shape_t n [NODES];

  fsic_shape u_shape (
    .clk_i  (clk_i),
    .kind_i (in_item_i.element_kind),
    .x_i    (in_item_i.pos_x),
    .y_i    (in_item_i.pos_y),
    .n_o    (n)
  );

  // Delay node values alongside the shape stages
  logic signed [VALUE_BITS-1:0] val_in [NODES];
  logic signed [VALUE_BITS-1:0] val1_q [NODES];
  logic signed [VALUE_BITS-1:0] val2_q [NODES];
  logic signed [VALUE_BITS-1:0] val3_q [NODES];

  assign val_in[0] = in_item_i.node_value_1;
  assign val_in[1] = in_item_i.node_value_2;
  assign val_in[2] = in_item_i.node_value_3;
  assign val_in[3] = in_item_i.node_value_4;
  assign val_in[4] = in_item_i.node_value_5;
  assign val_in[5] = in_item_i.node_value_6;
  assign val_in[6] = in_item_i.node_value_7;
  assign val_in[7] = in_item_i.node_value_8;
  assign val_in[8] = in_item_i.node_value_9;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NODES; k++) begin
      val1_q[k] <= val_in[k];
      val2_q[k] <= val1_q[k];
      val3_q[k] <= val2_q[k];
    end
  end

  // Node lanes: value times shape function
  logic signed [ACC_BITS-1:0] prod_q [NODES];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NODES; k++) begin
      prod_q[k] <= ACC_BITS'(val3_q[k]) * ACC_BITS'(n[k]);
    end
  end

  // Merge lanes: partial sums, then final sum and rounding to Q16.16
  logic signed [ACC_BITS-1:0] psum_q [3];
  logic signed [ACC_BITS-1:0] sum, g_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      psum_q[j] <= prod_q[3*j] + prod_q[3*j+1] + prod_q[3*j+2];
    end
  end

  assign sum = psum_q[0] + psum_q[1] + psum_q[2] + (ACC_BITS'(1) <<< (F - 1));

  always_ff @(posedge clk_i) begin
    g_q <= sum >>> F;
  end

  // Decide target color, clamped magnitude and limit
  logic signed [ACC_BITS-1:0] max_ext, min_ext, lim;
  logic [ACC_BITS-1:0]        mg_full;
  logic [VALUE_BITS-1:0]      ml, mg;
  logic                       above, below, pos;
  logic [CHANNEL_BITS-1:0]    tgt_d [3];
  logic [CHANNEL_BITS-1:0]    tgt_q [3];
  logic [CHANNEL_BITS-1:0]    neu_q [3];
  logic [VALUE_BITS-1:0]      mg_d, ml_d, mg_q, ml_q;

  assign max_ext = ACC_BITS'(max_q);
  assign min_ext = ACC_BITS'(min_q);
  assign above   = g_q > max_ext;
  assign below   = g_q < min_ext;
  assign pos     = g_q > 0;
  assign lim     = pos ? max_ext : min_ext;
  assign ml      = VALUE_BITS'(lim[ACC_BITS-1] ? -lim : lim);
  assign mg_full = g_q[ACC_BITS-1] ? ACC_BITS'(-g_q) : ACC_BITS'(g_q);
  assign mg      = (mg_full > ACC_BITS'(ml)) ? ml : mg_full[VALUE_BITS-1:0];

  // Fixed colors run through the divider as c*1/1
  always_comb begin
    mg_d = VALUE_BITS'(1);
    ml_d = VALUE_BITS'(1);
    for (int k = 0; k < 3; k++) begin
      priority if (above) begin
        tgt_d[k] = cpos_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS];
      end else if (below) begin
        tgt_d[k] = cneg_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS];
      end else if (ml == '0) begin
        tgt_d[k] = cneu_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS];
      end else begin
        tgt_d[k] = pos ? cpos_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS]
                       : cneg_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS];
      end
    end
    if (!above && !below && (ml != '0)) begin
      mg_d = mg;
      ml_d = ml;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      tgt_q[k] <= tgt_d[k];
      neu_q[k] <= cneu_q[(2-k)*CHANNEL_BITS +: CHANNEL_BITS];
    end
    mg_q <= mg_d;
    ml_q <= ml_d;
  end

  // Blend numerators
  logic [NUM_BITS-1:0]   num_q [3];
  logic [VALUE_BITS-1:0] den_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      num_q[k] <= NUM_BITS'(tgt_q[k]) * NUM_BITS'(mg_q)
                + NUM_BITS'(neu_q[k]) * NUM_BITS'(ml_q - mg_q)
                + NUM_BITS'(ml_q >> 1);
    end
    den_q <= ml_q;
  end

  // Per-channel divider lanes
  logic [CHANNEL_BITS-1:0] quo [3];
  logic [2:0]              div_vld;

  for (genvar k = 0; k < 3; k++) begin : g_chan
    fsic_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_q[7]),
      .num_i   (num_q[k]),
      .den_i   (den_q),
      .valid_o (div_vld[k]),
      .quo_o   (quo[k])
    );
  end

  assign done_o         = &div_vld;
  assign result_o.red   = quo[0];
  assign result_o.green = quo[1];
  assign result_o.blue  = quo[2];

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a matching item");

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld == 3'b000) || (div_vld == 3'b111))
    else $error("divider lanes out of step");

  a_fixed_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] && $past(above || below) |-> (ml_q == VALUE_BITS'(1)))
    else $error("saturated color not routed as unit divide");
`endif

endmodule
`default_nettype wire

### hw/rtl/fsic_shape.sv
`default_nettype none
module fsic_shape (
  input  logic                                  clk_i,
  input  fsic_pkg::kind_t                       kind_i,
  input  logic signed [fsic_pkg::POS_BITS-1:0]  x_i,
  input  logic signed [fsic_pkg::POS_BITS-1:0]  y_i,
  output fsic_pkg::shape_t                      n_o [fsic_pkg::NODES]
);
  import fsic_pkg::*;

  localparam int unsigned F = POS_FRAC_BITS;
  localparam shape_t One = SHAPE_BITS'(1) << F;

  // Product with round-half-up arithmetic shift
  function automatic shape_t mulsh(input shape_t a, input shape_t b, input int unsigned sh);
    logic signed [2*SHAPE_BITS-1:0] p;
    p = a * b;
    p = p + ((2*SHAPE_BITS)'(1) << (sh - 1));
    return SHAPE_BITS'(p >>> sh);
  endfunction

  // Stage a: saturate coordinates
  shape_t xe, ye, xa_d, ya_d, xa_q, ya_q;
  kind_t  kind_a_q;

  assign xe = SHAPE_BITS'(x_i);
  assign ye = SHAPE_BITS'(y_i);
  assign xa_d = (xe > One) ? One : ((xe < -One) ? -One : xe);
  assign ya_d = (ye > One) ? One : ((ye < -One) ? -One : ye);

  always_ff @(posedge clk_i) begin
    xa_q     <= xa_d;
    ya_q     <= ya_d;
    kind_a_q <= kind_i;
  end

  // Stage b: first-level products
  shape_t l_a;
  shape_t xb_q, yb_q, lb_q, bx_q, by_q, axm_q, axp_q, aym_q, ayp_q;
  shape_t q8_q [4];
  shape_t t6_q [6];
  shape_t q4_q [4];
  kind_t  kind_b_q;

  assign l_a = One - xa_q - ya_q;

  always_ff @(posedge clk_i) begin
    xb_q     <= xa_q;
    yb_q     <= ya_q;
    lb_q     <= l_a;
    kind_b_q <= kind_a_q;
    bx_q     <= mulsh(One - xa_q, One + xa_q, F);
    by_q     <= mulsh(One - ya_q, One + ya_q, F);
    axm_q    <= mulsh(xa_q - One, xa_q, F);
    axp_q    <= mulsh(xa_q, xa_q + One, F);
    aym_q    <= mulsh(ya_q - One, ya_q, F);
    ayp_q    <= mulsh(ya_q, ya_q + One, F);
    q8_q[0]  <= mulsh(xa_q - One, One - ya_q, F);
    q8_q[1]  <= mulsh(xa_q + One, ya_q - One, F);
    q8_q[2]  <= mulsh(xa_q + One, ya_q + One, F);
    q8_q[3]  <= mulsh(One - xa_q, ya_q + One, F);
    t6_q[0]  <= mulsh((l_a <<< 1) - One, l_a, F);
    t6_q[1]  <= mulsh(xa_q, (xa_q <<< 1) - One, F);
    t6_q[2]  <= mulsh(ya_q, (ya_q <<< 1) - One, F);
    t6_q[3]  <= mulsh(xa_q <<< 2, l_a, F);
    t6_q[4]  <= mulsh(xa_q <<< 2, ya_q, F);
    t6_q[5]  <= mulsh(ya_q <<< 2, l_a, F);
    q4_q[0]  <= mulsh(One - xa_q, One - ya_q, F + 2);
    q4_q[1]  <= mulsh(One + xa_q, One - ya_q, F + 2);
    q4_q[2]  <= mulsh(One + xa_q, One + ya_q, F + 2);
    q4_q[3]  <= mulsh(One - xa_q, One + ya_q, F + 2);
  end

  // Stage c: second-level products, select by kind
  shape_t n_d [NODES];
  shape_t n_q [NODES];

  always_comb begin
    for (int k = 0; k < NODES; k++) n_d[k] = '0;
    unique case (kind_b_q)
      KIND_TRI3: begin
        n_d[0] = lb_q; n_d[1] = xb_q; n_d[2] = yb_q;
      end
      KIND_TRI6: begin
        for (int k = 0; k < 6; k++) n_d[k] = t6_q[k];
      end
      KIND_QUAD4: begin
        for (int k = 0; k < 4; k++) n_d[k] = q4_q[k];
      end
      KIND_QUAD8: begin
        n_d[0] = mulsh(q8_q[0], One + xb_q + yb_q, F + 2);
        n_d[1] = mulsh(q8_q[1], yb_q - xb_q + One, F + 2);
        n_d[2] = mulsh(q8_q[2], yb_q + xb_q - One, F + 2);
        n_d[3] = mulsh(q8_q[3], yb_q - xb_q - One, F + 2);
        n_d[4] = mulsh(bx_q, One - yb_q, F + 1);
        n_d[5] = mulsh(One + xb_q, by_q, F + 1);
        n_d[6] = mulsh(bx_q, One + yb_q, F + 1);
        n_d[7] = mulsh(One - xb_q, by_q, F + 1);
      end
      KIND_QUAD9: begin
        n_d[0] = mulsh(axm_q, aym_q, F + 2);
        n_d[1] = mulsh(axp_q, aym_q, F + 2);
        n_d[2] = mulsh(axp_q, ayp_q, F + 2);
        n_d[3] = mulsh(axm_q, ayp_q, F + 2);
        n_d[4] = mulsh(bx_q, aym_q, F + 1);
        n_d[5] = mulsh(axp_q, by_q, F + 1);
        n_d[6] = mulsh(bx_q, ayp_q, F + 1);
        n_d[7] = mulsh(axm_q, by_q, F + 1);
        n_d[8] = mulsh(bx_q, by_q, F);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NODES; k++) n_q[k] <= n_d[k];
  end

  assign n_o = n_q;

endmodule
`default_nettype wire

### hw/rtl/fsic_div.sv
`default_nettype none
module fsic_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [fsic_pkg::NUM_BITS-1:0]       num_i,
  input  logic [fsic_pkg::VALUE_BITS-1:0]     den_i,
  output logic                                valid_o,
  output logic [fsic_pkg::CHANNEL_BITS-1:0]   quo_o
);
  import fsic_pkg::*;

  logic                    vld_q [CHANNEL_BITS];
  logic [NUM_BITS-1:0]     rem_q [CHANNEL_BITS];
  logic [VALUE_BITS-1:0]   den_q [CHANNEL_BITS];
  logic [CHANNEL_BITS-1:0] quo_q [CHANNEL_BITS];

  // One restoring step per stage, quotient MSB first
  for (genvar s = 0; s < CHANNEL_BITS; s++) begin : g_stage
    localparam int unsigned Shift = CHANNEL_BITS - 1 - s;
    logic                    vld_in;
    logic [NUM_BITS-1:0]     rem_in, sub;
    logic [VALUE_BITS-1:0]   den_in;
    logic [CHANNEL_BITS-1:0] quo_in;
    logic                    take;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sub  = NUM_BITS'(den_in) << Shift;
    assign take = (rem_in >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? (rem_in - sub) : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= {quo_in[CHANNEL_BITS-2:0], take};
    end
  end

  assign valid_o = vld_q[CHANNEL_BITS-1];
  assign quo_o   = quo_q[CHANNEL_BITS-1];

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (den_i != '0))
    else $error("divider fed a zero divisor");

  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (num_i < (NUM_BITS'(den_i) << CHANNEL_BITS)))
    else $error("quotient overflows the channel width");

  a_first_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> (quo_q[0][0] == (rem_q[0] != $past(num_i))))
    else $error("first divider step inconsistent");
`endif

endmodule
`default_nettype wire
